>>> design/assert_macros.svh
// assertion macros used by the top level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("assertion failed");
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_CLK(lbl, clk, rstn, prop)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

>>> design/bfd_pkg.sv
// constants and codes of the byte frame deframer
`timescale 1ns / 1ps
`default_nettype none
package bfd_pkg;
    localparam logic [7:0] HEAD_MARK      = 8'hBE;
    localparam logic [7:0] TAIL_MARK      = 8'hED;
    localparam logic [1:0] KIND_PAYLOAD   = 2'd0;
    localparam logic [1:0] KIND_EMPTY     = 2'd1;
    localparam logic [1:0] KIND_OVERFLOW  = 2'd2;
    localparam int         FRAME_OVERHEAD = 6;
    localparam logic [6:0] MAX_RESULTS    = 7'd64;
    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] frame_type;
        logic [7:0] payload_byte;
        logic [5:0] frame_length;
        logic       end_of_frame;
    } t_result;
endpackage
`default_nettype wire

>>> design/bfd_ram.sv
// generic simple dual port ram with registered read
`timescale 1ns / 1ps
`default_nettype none
module bfd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire                     i_clk,
    input  wire                     i_we,
    input  wire [$clog2(DEPTH)-1:0] i_waddr,
    input  wire [WIDTH-1:0]         i_wdata,
    input  wire                     i_re,
    input  wire [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]        o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule
`default_nettype wire

>>> design/byte_frame_deframer_sum8.sv
// top level of the byte frame deframer with 8-bit sum check
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
// channel | valid       | stall        | payload
// in      | i_in_valid  | o_in_stall   | i_rx_byte
// out     | o_out_valid | i_out_stall  | o_kind o_frame_type o_payload_byte o_frame_length
//         |             |              | o_end_of_frame o_last
// one request is taken only while the sequencer is idle; a byte that finds the store
// full gives one overflow result, otherwise the store ring is rescanned
// rescan cost is set by the single read port: each skipped byte, the head and
// length bytes, the checksum and tail, and every summed or delivered byte is read
// in turn between taking the request and finishing; a frame whose check fails
// restarts the scan at the next head byte
// results leave one behind the scan so the final one can carry last
// reset empties the ring (fill count zero), no clearing pass is needed
// output stall only holds the sequencer where a result must be pushed
module byte_frame_deframer_sum8 import bfd_pkg::*; #(
    parameter int BUFFER_DEPTH = 64
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_in_valid,
    output logic       o_in_stall,
    input  wire [7:0]  i_rx_byte,
    output logic       o_out_valid,
    input  wire        i_out_stall,
    output logic [1:0] o_kind,
    output logic [7:0] o_frame_type,
    output logic [7:0] o_payload_byte,
    output logic [5:0] o_frame_length,
    output logic       o_end_of_frame,
    output logic       o_last
);
    localparam int AW = $clog2(BUFFER_DEPTH);
    localparam int CW = $clog2(BUFFER_DEPTH + 1);
    localparam logic [CW:0]   DEPTH_W  = (CW+1)'(BUFFER_DEPTH);
    localparam logic [CW-1:0] DEPTH_C  = CW'(BUFFER_DEPTH);
    localparam logic [16:0]   DEPTH_17 = 17'(BUFFER_DEPTH);

    // sequencer codes
    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_HREQ = 4'd1;
    localparam logic [3:0] S_HCHK = 4'd2;
    localparam logic [3:0] S_L2   = 4'd3;
    localparam logic [3:0] S_L3   = 4'd4;
    localparam logic [3:0] S_SUM  = 4'd5;
    localparam logic [3:0] S_CK   = 4'd6;
    localparam logic [3:0] S_TL   = 4'd7;
    localparam logic [3:0] S_PAY  = 4'd8;
    localparam logic [3:0] S_EMP  = 4'd9;
    localparam logic [3:0] S_DONE = 4'd10;

    // ring position of offset from the oldest byte
    function automatic logic [AW-1:0] f_addr(input logic [AW-1:0] b, input logic [CW-1:0] off);
        logic [CW:0] s;
        s = (CW+1)'(b) + {1'b0, off};
        if (s >= DEPTH_W) begin
            s = s - DEPTH_W;
        end
        return s[AW-1:0];
    endfunction

    logic [3:0]    r_st, n_st;
    logic [AW-1:0] r_base, n_base;
    logic [CW-1:0] r_fill, n_fill;
    logic [CW-1:0] r_idx, n_idx;
    logic [CW-1:0] r_total, n_total;
    logic [15:0]   r_plen, n_plen;
    logic [7:0]    r_sum, n_sum;
    logic [7:0]    r_type, n_type;
    logic          r_ckok, n_ckok;
    logic [6:0]    r_cnt, n_cnt;
    logic          r_pv, n_pv;
    t_result       r_pend, n_pend;
    logic          r_ov, n_ov;
    t_result       r_out, n_out;
    logic          r_olast, n_olast;

    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic [7:0]    rd_data;
    logic          wr_en;
    logic [16:0]   total;
    logic          out_free;
    logic          can_push;
    logic          push;
    t_result       new_res;
    logic [CW-1:0] drop_n;
    logic          drop;

    bfd_ram #(.WIDTH(8), .DEPTH(BUFFER_DEPTH)) u_ram (
        .i_clk  (i_clk),
        .i_we   (wr_en),
        .i_waddr(f_addr(r_base, r_fill)),
        .i_wdata(i_rx_byte),
        .i_re   (rd_en),
        .i_raddr(rd_addr),
        .o_rdata(rd_data)
    );

    assign o_in_stall = (r_st != S_IDLE);
    assign wr_en      = i_in_valid && (r_st == S_IDLE) && (r_fill != DEPTH_C);
    assign out_free   = !r_ov || !i_out_stall;
    assign can_push   = !r_pv || out_free;
    // frame size from the high length byte and the low byte being read
    assign total      = {1'b0, r_plen[15:8], rd_data} + 17'(FRAME_OVERHEAD);

    always_comb begin
        n_st = r_st; n_base = r_base; n_fill = r_fill; n_idx = r_idx;
        n_total = r_total; n_plen = r_plen; n_sum = r_sum; n_type = r_type;
        n_ckok = r_ckok; n_cnt = r_cnt; n_pv = r_pv; n_pend = r_pend;
        n_ov = r_ov && i_out_stall; n_out = r_out; n_olast = r_olast;
        rd_en = 1'b0; rd_addr = r_base;
        push = 1'b0; drop = 1'b0; drop_n = CW'(1);
        new_res = '{kind: KIND_PAYLOAD, frame_type: r_type, payload_byte: rd_data,
                    frame_length: r_plen[5:0], end_of_frame: 1'b0};
        case (r_st)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_cnt = 7'd0;
                    if (r_fill == DEPTH_C) begin
                        n_pv = 1'b1;
                        n_pend = '{kind: KIND_OVERFLOW, frame_type: 8'd0,
                                   payload_byte: 8'd0, frame_length: 6'd0,
                                   end_of_frame: 1'b0};
                        n_st = S_DONE;
                    end else begin
                        n_fill = r_fill + CW'(1);
                        n_st = S_HREQ;
                    end
                end
            end
            S_HREQ: begin
                if (r_fill == '0) begin
                    n_st = S_DONE;
                end else begin
                    rd_en = 1'b1; rd_addr = r_base; n_st = S_HCHK;
                end
            end
            S_HCHK: begin
                if (rd_data != HEAD_MARK) begin
                    drop = 1'b1; n_st = S_HREQ;
                end else if (r_fill < CW'(FRAME_OVERHEAD)) begin
                    n_st = S_DONE;
                end else begin
                    rd_en = 1'b1; rd_addr = f_addr(r_base, CW'(2)); n_st = S_L2;
                end
            end
            S_L2: begin
                n_plen = {rd_data, r_plen[7:0]};
                rd_en = 1'b1; rd_addr = f_addr(r_base, CW'(3)); n_st = S_L3;
            end
            S_L3: begin
                n_plen = {r_plen[15:8], rd_data};
                n_total = total[CW-1:0];
                if (total > DEPTH_17) begin
                    drop = 1'b1; n_st = S_HREQ;
                end else if (17'(r_fill) < total) begin
                    n_st = S_DONE;
                end else begin
                    n_idx = '0; n_sum = 8'd0;
                    rd_en = 1'b1; rd_addr = r_base; n_st = S_SUM;
                end
            end
            S_SUM: begin
                n_sum = r_sum + rd_data;
                if (r_idx == CW'(1)) begin
                    n_type = rd_data;
                end
                if (r_idx == r_total - CW'(3)) begin
                    rd_en = 1'b1; rd_addr = f_addr(r_base, r_total - CW'(2)); n_st = S_CK;
                end else begin
                    n_idx = r_idx + CW'(1);
                    rd_en = 1'b1; rd_addr = f_addr(r_base, r_idx + CW'(1)); n_st = S_SUM;
                end
            end
            S_CK: begin
                n_ckok = (rd_data == r_sum);
                rd_en = 1'b1; rd_addr = f_addr(r_base, r_total - CW'(1)); n_st = S_TL;
            end
            S_TL: begin
                if (!r_ckok || rd_data != TAIL_MARK) begin
                    drop = 1'b1; n_st = S_HREQ;
                end else if (r_plen == 16'd0) begin
                    n_st = S_EMP;
                end else begin
                    n_idx = '0;
                    rd_en = 1'b1; rd_addr = f_addr(r_base, CW'(4)); n_st = S_PAY;
                end
            end
            S_PAY: begin
                new_res.end_of_frame = (r_idx == r_plen[CW-1:0] - CW'(1));
                if (can_push) begin
                    push = 1'b1;
                    if (new_res.end_of_frame) begin
                        drop = 1'b1; drop_n = r_total; n_st = S_HREQ;
                    end else begin
                        n_idx = r_idx + CW'(1);
                        rd_en = 1'b1; rd_addr = f_addr(r_base, r_idx + CW'(5));
                    end
                end
            end
            S_EMP: begin
                new_res.kind = KIND_EMPTY;
                new_res.payload_byte = 8'd0;
                new_res.frame_length = 6'd0;
                new_res.end_of_frame = 1'b1;
                if (can_push) begin
                    push = 1'b1; drop = 1'b1; drop_n = r_total; n_st = S_HREQ;
                end
            end
            S_DONE: begin
                if (!r_pv) begin
                    n_st = S_IDLE;
                end else if (out_free) begin
                    n_ov = 1'b1; n_out = r_pend; n_olast = 1'b1;
                    n_pv = 1'b0; n_st = S_IDLE;
                end
            end
            default: n_st = S_IDLE;
        endcase
        // results past the cap are consumed but not delivered
        if (push && r_cnt < MAX_RESULTS) begin
            n_cnt = r_cnt + 7'd1;
            if (r_pv) begin
                n_ov = 1'b1; n_out = r_pend; n_olast = 1'b0;
            end
            n_pv = 1'b1; n_pend = new_res;
        end
        if (drop) begin
            n_base = f_addr(r_base, drop_n);
            n_fill = r_fill - drop_n;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= S_IDLE;
            r_base <= '0;
            r_fill <= '0;
            r_pv   <= 1'b0;
            r_ov   <= 1'b0;
            r_cnt  <= 7'd0;
        end else begin
            r_st   <= n_st;
            r_base <= n_base;
            r_fill <= n_fill;
            r_pv   <= n_pv;
            r_ov   <= n_ov;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx   <= n_idx;
        r_total <= n_total;
        r_plen  <= n_plen;
        r_sum   <= n_sum;
        r_type  <= n_type;
        r_ckok  <= n_ckok;
        r_pend  <= n_pend;
        r_out   <= n_out;
        r_olast <= n_olast;
    end

    assign o_out_valid    = r_ov;
    assign o_kind         = r_out.kind;
    assign o_frame_type   = r_out.frame_type;
    assign o_payload_byte = r_out.payload_byte;
    assign o_frame_length = r_out.frame_length;
    assign o_end_of_frame = r_out.end_of_frame;
    assign o_last         = r_olast;

    `ASSERT_CLK(a_fill_bound, i_clk, i_rst_n, r_fill <= DEPTH_C)
    `ASSERT_CLK(a_base_bound, i_clk, i_rst_n, 32'(r_base) < BUFFER_DEPTH)
    `ASSERT_CLK(a_idle_no_pend, i_clk, i_rst_n, (r_st == S_IDLE) |-> !r_pv)
    `ASSERT_NEXT(a_done_idle, i_clk, i_rst_n, (r_st == S_DONE) && !r_pv, r_st == S_IDLE)
endmodule
`default_nettype wire

>>> dv/byte_frame_deframer_sum8_chk.sv
// checker of the byte frame deframer: predicts frames from accepted bytes and compares results
`timescale 1ns / 1ps
module byte_frame_deframer_sum8_chk import bfd_pkg::*; #(
    parameter int BUFFER_DEPTH = 64
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_in_valid,
    input  wire        i_in_stall,
    input  wire [7:0]  i_rx_byte,
    input  wire        i_out_valid,
    input  wire        i_out_stall,
    input  wire [1:0]  i_kind,
    input  wire [7:0]  i_frame_type,
    input  wire [7:0]  i_payload_byte,
    input  wire [5:0]  i_frame_length,
    input  wire        i_end_of_frame,
    input  wire        i_last,
    output int         o_errors,
    output int         o_pending
);
    typedef struct packed {
        t_result    res;
        logic       last;
    } t_expect;

    logic [7:0] rx_store[$];
    t_expect    expected_results[$];
    int         errors;

    assign o_errors  = errors;
    assign o_pending = expected_results.size();

    // remove n bytes from the front of the predicted store
    task automatic drop_bytes(input int n);
        for (int k = 0; k < n && rx_store.size() > 0; k++) void'(rx_store.pop_front());
    endtask

    task automatic push_result(input logic [1:0] kind, input logic [7:0] ftype,
                               input logic [7:0] data, input logic [5:0] flen,
                               input logic eof);
        t_expect e;
        e.res.kind = kind;
        e.res.frame_type = ftype;
        e.res.payload_byte = data;
        e.res.frame_length = flen;
        e.res.end_of_frame = eof;
        e.last = 1'b0;
        expected_results.push_back(e);
    endtask

    task automatic deframe_byte(input logic [7:0] rx);
        int    base;
        int    plen;
        int    total;
        logic [7:0] sum;
        t_expect e;
        base = expected_results.size();
        if (rx_store.size() >= BUFFER_DEPTH) begin
            push_result(KIND_OVERFLOW, 8'd0, 8'd0, 6'd0, 1'b0);
        end else begin
            rx_store.push_back(rx);
            forever begin
                while (rx_store.size() > 0 && rx_store[0] != HEAD_MARK)
                    void'(rx_store.pop_front());
                if (rx_store.size() < FRAME_OVERHEAD) break;
                plen = {rx_store[2], rx_store[3]};
                total = plen + FRAME_OVERHEAD;
                if (total > BUFFER_DEPTH) begin
                    drop_bytes(1);
                    continue;
                end
                if (rx_store.size() < total) break;
                sum = '0;
                for (int k = 0; k < total - 2; k++) sum += rx_store[k];
                if (rx_store[total-1] != TAIL_MARK || rx_store[total-2] != sum) begin
                    drop_bytes(1);
                    continue;
                end
                if (plen == 0)
                    push_result(KIND_EMPTY, rx_store[1], 8'd0, 6'd0, 1'b1);
                else
                    for (int k = 0; k < plen; k++)
                        push_result(KIND_PAYLOAD, rx_store[1], rx_store[4+k], plen[5:0],
                                    k + 1 == plen);
                drop_bytes(total);
            end
        end
        if (expected_results.size() > base) begin
            e = expected_results[$];
            e.last = 1'b1;
            expected_results[expected_results.size()-1] = e;
        end
    endtask

    always @(posedge i_clk) begin
        t_expect e;
        if (!i_rst_n) begin
            rx_store.delete();
            expected_results.delete();
            errors = 0;
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (expected_results.size() == 0) begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected result kind=%0d type=%h data=%h",
                                 i_kind, i_frame_type, i_payload_byte);
                end else begin
                    e = expected_results.pop_front();
                    if (i_kind !== e.res.kind || i_frame_type !== e.res.frame_type ||
                        i_payload_byte !== e.res.payload_byte ||
                        i_frame_length !== e.res.frame_length ||
                        i_end_of_frame !== e.res.end_of_frame || i_last !== e.last) begin
                        errors++;
                        if (errors <= 10)
                            $display("mismatch exp k=%0d t=%h d=%h l=%0d eof=%b last=%b %s",
                                     e.res.kind, e.res.frame_type, e.res.payload_byte,
                                     e.res.frame_length, e.res.end_of_frame, e.last,
                                     $sformatf("got k=%0d t=%h d=%h l=%0d eof=%b last=%b",
                                     i_kind, i_frame_type, i_payload_byte,
                                     i_frame_length, i_end_of_frame, i_last));
                    end
                end
            end
            if (i_in_valid && !i_in_stall) deframe_byte(i_rx_byte);
        end
    end
endmodule

>>> dv/byte_frame_deframer_sum8_tb.sv
// testbench top of the byte frame deframer: stimulus, idling phases and verdict
`timescale 1ns / 1ps
module byte_frame_deframer_sum8_tb;
    import bfd_pkg::*;

    localparam int CYCLE_LIMIT = 900000;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic [7:0] rx_byte = 8'd0;
    logic       out_stall = 1'b0;
    wire        in_stall;
    wire        out_valid;
    wire [1:0]  kind;
    wire [7:0]  frame_type;
    wire [7:0]  payload_byte;
    wire [5:0]  frame_length;
    wire        end_of_frame;
    wire        last;
    int         errors;
    int         pending;
    int         cycles = 0;
    // idling percentages for the current phase
    int         send_idle_pct = 0;
    int         recv_stall_pct = 0;
    // long receiver hold-off, run in its own process
    int         holdoff_cycles = 0;
    logic [7:0] byte_q[$];

    always #4 clk = ~clk;

    byte_frame_deframer_sum8 u_top (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .o_in_stall(in_stall), .i_rx_byte(rx_byte),
        .o_out_valid(out_valid), .i_out_stall(out_stall),
        .o_kind(kind), .o_frame_type(frame_type), .o_payload_byte(payload_byte),
        .o_frame_length(frame_length), .o_end_of_frame(end_of_frame), .o_last(last)
    );

    byte_frame_deframer_sum8_chk u_chk (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .i_in_stall(in_stall), .i_rx_byte(rx_byte),
        .i_out_valid(out_valid), .i_out_stall(out_stall),
        .i_kind(kind), .i_frame_type(frame_type), .i_payload_byte(payload_byte),
        .i_frame_length(frame_length), .i_end_of_frame(end_of_frame), .i_last(last),
        .o_errors(errors), .o_pending(pending)
    );

    // watchdog
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // receiver stall, changed at the falling edge
    always @(negedge clk) begin
        if (holdoff_cycles > 0) begin
            out_stall <= 1'b1;
            holdoff_cycles <= holdoff_cycles - 1;
        end else begin
            out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // queue one frame; bad_sum / bad_tail corrupt it
    task automatic add_frame(input logic [7:0] ftype, input int plen,
                             input bit bad_sum, input bit bad_tail);
        logic [7:0] sum;
        logic [7:0] b;
        sum = HEAD_MARK + ftype + plen[15:8] + plen[7:0];
        byte_q.push_back(HEAD_MARK);
        byte_q.push_back(ftype);
        byte_q.push_back(plen[15:8]);
        byte_q.push_back(plen[7:0]);
        for (int k = 0; k < plen; k++) begin
            b = 8'($urandom_range(255));
            sum += b;
            byte_q.push_back(b);
        end
        byte_q.push_back(bad_sum ? sum ^ 8'h01 : sum);
        byte_q.push_back(bad_tail ? 8'h00 : TAIL_MARK);
    endtask

    // send every queued byte as a request, with random sender gaps
    task automatic send_queue();
        while (byte_q.size() > 0) begin
            if ($urandom_range(99) < send_idle_pct) begin
                in_valid <= 1'b0;
                @(negedge clk);
            end else begin
                in_valid <= 1'b1;
                rx_byte  <= byte_q.pop_front();
                @(posedge clk);
                while (in_stall) @(posedge clk);
                @(negedge clk);
            end
        end
        in_valid <= 1'b0;
    endtask

    // let the block drain so queued partial frames do not run into the next phase
    task automatic drain();
        while (pending != 0) @(negedge clk);
        repeat (200) @(negedge clk);
    endtask

    // queue random entries until about n bytes are waiting, then send them
    task automatic random_traffic(input int n);
        int r;
        int plen;
        while (byte_q.size() < n) begin
            r = int'($urandom_range(99));
            plen = ($urandom_range(9) == 0) ? int'($urandom_range(12))
                                            : int'($urandom_range(6));
            if (r < 65) add_frame(8'($urandom_range(255)), plen, 0, 0);
            else if (r < 75) add_frame(8'($urandom_range(255)), plen, 1, 0);
            else if (r < 82) add_frame(8'($urandom_range(255)), plen, 0, 1);
            else if (r < 88) begin
                // oversized length with no frame body after it
                byte_q.push_back(HEAD_MARK);
                byte_q.push_back(8'($urandom_range(255)));
                byte_q.push_back(8'($urandom_range(255)));
                byte_q.push_back(8'd59 + 8'($urandom_range(196)));
            end else begin
                repeat ($urandom_range(3, 1)) byte_q.push_back(8'($urandom_range(255)));
            end
        end
        send_queue();
    endtask

    initial begin
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: junk ahead, empty frame, max and min types, long payload,
        // bad sum, bad tail
        byte_q.push_back(8'h00);
        byte_q.push_back(8'hFF);
        add_frame(8'hFF, 0, 0, 0);
        add_frame(8'h00, 33, 0, 0);
        add_frame(8'h5A, 0, 1, 0);
        add_frame(8'hA5, 1, 0, 1);
        // oversized: length 0xFFFF, then 59
        byte_q.push_back(HEAD_MARK); byte_q.push_back(8'h01);
        byte_q.push_back(8'hFF); byte_q.push_back(8'hFF);
        byte_q.push_back(HEAD_MARK); byte_q.push_back(8'h02);
        byte_q.push_back(8'h00); byte_q.push_back(8'd59);
        send_queue();
        drain();

        send_idle_pct = 0;  recv_stall_pct = 0;  random_traffic(6);
        drain();
        send_idle_pct = 76; recv_stall_pct = 0;  random_traffic(6);
        drain();
        send_idle_pct = 0;  recv_stall_pct = 76; random_traffic(6);
        drain();
        // long receiver hold-off while the sender keeps offering requests
        send_idle_pct = 0;  recv_stall_pct = 0;
        holdoff_cycles = 3000;
        add_frame(8'h77, 4, 0, 0);
        random_traffic(12);
        drain();
        send_idle_pct = 12; recv_stall_pct = 12; random_traffic(6);
        drain();
        recv_stall_pct = 0;
        repeat (100) @(negedge clk);

        if (errors == 0 && pending == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule
